// File: rtl/text_console_with_scrollback_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the text console
// Shared property forms; clock clk, synchronous active-low reset rst_n.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WITH_SCROLLBACK_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WITH_SCROLLBACK_UNIT_DEFINES_SVH

// Condition holds at every edge out of reset.
`define TCSU_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define TCSU_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TCSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tcsu_pkg.sv
// ---------------------------------------------------------------------------
// tcsu_pkg
// Types, codes and defaults shared by the text console modules.
// ---------------------------------------------------------------------------
package tcsu_pkg;

  localparam int DEF_SCREEN_COLUMNS = 80;
  localparam int DEF_SCREEN_ROWS    = 25;
  localparam int DEF_HISTORY_DEPTH  = 4096;
  localparam int DEF_QUEUE_DEPTH    = 2;

  localparam int TAB_STOP = 4;
  localparam int TAB_W    = $clog2(TAB_STOP + 1);

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  localparam logic [7:0] RESET_ATTRIBUTE = 8'h0F;

  localparam logic [1:0] MODE_WRITE        = 2'd0;
  localparam logic [1:0] MODE_READ_SCREEN  = 2'd1;
  localparam logic [1:0] MODE_READ_HISTORY = 2'd2;

  typedef enum logic [2:0] {
    OP_PLAIN,
    OP_NEWLINE,
    OP_RETURN,
    OP_BACKSPACE,
    OP_TAB,
    OP_READ_SCREEN,
    OP_READ_HISTORY,
    OP_NOP
  } tcsu_op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUT,
    ST_SCROLL,
    ST_RADDR,
    ST_RMUL,
    ST_RMEM,
    ST_RDATA,
    ST_REPORT
  } tcsu_state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  char_code;
    logic [4:0]  read_row;
    logic [6:0]  read_column;
    logic [11:0] history_age;
  } tcsu_in_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic [15:0] cell_data;
    logic        read_valid;
    logic [12:0] history_lines;
  } tcsu_out_t;

  typedef struct packed {
    tcsu_op_t    op;
    logic [7:0]  char_code;
    logic [4:0]  read_row;
    logic [6:0]  read_column;
    logic [11:0] history_age;
  } tcsu_cmd_t;

endpackage

// File: rtl/text_console_with_scrollback_unit.sv
// ---------------------------------------------------------------------------
// text_console_with_scrollback_unit
// Text console with screen memory, cursor and a history ring of old rows.
// ---------------------------------------------------------------------------
// Sequence: characters and each space of a tab are written in ST_PUT, control
//   codes act in ST_IDLE, reads pass ST_RADDR, ST_RMUL, ST_RMEM and ST_RDATA,
//   a scroll runs ST_SCROLL over the top row, and every item ends in ST_REPORT.
// Throughput: the back sets the rate; the queue takes items while the back is busy.
// Reset: synchronous; busy stays high while the whole screen memory is swept to
//   blanks. Results cannot be stalled by the receiver.
module text_console_with_scrollback_unit import tcsu_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS,
  parameter int HISTORY_DEPTH  = DEF_HISTORY_DEPTH,
  parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  // item channel: accepted when start is high and busy is low
  input  logic       start,
  output logic       busy,
  input  tcsu_in_t   in_item,
  // result channel: one cycle per result, no back-pressure
  output logic       out_strobe,
  output tcsu_out_t  out_item,
  // attribute register
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  // Attribute byte applied to written characters and to blanks made by backspace
  // and scroll. Writes must arrive only while the console is idle; the block does not enforce it.
  logic [7:0] attr_r, attr_nxt;

  // front -> queue
  logic      push;
  tcsu_cmd_t push_cmd;

  // queue -> back
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  tcsu_cmd_t q_head;

  // back is sweeping the screen after reset; hold the front off
  logic      clearing;

  assign attr_nxt = cfg_we ? cfg_wdata : attr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= RESET_ATTRIBUTE;
    end else begin
      attr_r <= attr_nxt;
    end
  end

  // Front: take the item, decode mode and control characters, drop
  // out-of-range reads to no-ops, and stage the command for the queue.
  tcsu_front #(
    .SCREEN_ROWS    (SCREEN_ROWS),
    .SCREEN_COLUMNS (SCREEN_COLUMNS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .hold_off (clearing),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Queue: decouple the front from the multi-cycle back end so a new item
  // can be taken while a scroll or read is still in progress.
  tcsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Back: run each command against the screen and history memories.
  // The screen is a circular set of rows, so a scroll moves one row to
  // history and blanks it in place instead of shifting the whole screen.
  tcsu_back #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS),
    .HISTORY_DEPTH  (HISTORY_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .attr       (attr_r),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// File: rtl/tcsu_queue.sv
// ---------------------------------------------------------------------------
// tcsu_queue
// Short command queue between the front classifier and the back sequencer.
// ---------------------------------------------------------------------------
module tcsu_queue import tcsu_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tcsu_cmd_t push_cmd,
  input  logic      pop,
  output logic      full,
  output logic      empty,
  output tcsu_cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tcsu_cmd_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/tcsu_front.sv
// ---------------------------------------------------------------------------
// tcsu_front
// Accepts items, sorts them into console commands and feeds the queue.
// ---------------------------------------------------------------------------
module tcsu_front import tcsu_pkg::*; #(
  parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS,
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  tcsu_in_t  in_item,
  input  logic      hold_off,
  input  logic      q_full,
  output logic      push,
  output tcsu_cmd_t push_cmd
);

  tcsu_cmd_t cls;
  tcsu_cmd_t cmd_r;
  logic      cmd_valid_r, cmd_valid_nxt;
  logic      accept;

  // classify: out-of-range reads become no-ops here
  always_comb begin
    cls.char_code   = in_item.char_code;
    cls.read_row    = in_item.read_row;
    cls.read_column = in_item.read_column;
    cls.history_age = in_item.history_age;
    cls.op          = OP_NOP;
    case (in_item.mode)
      MODE_WRITE: begin
        case (in_item.char_code)
          CH_NEWLINE:   cls.op = OP_NEWLINE;
          CH_RETURN:    cls.op = OP_RETURN;
          CH_BACKSPACE: cls.op = OP_BACKSPACE;
          CH_TAB:       cls.op = OP_TAB;
          default:      cls.op = OP_PLAIN;
        endcase
      end
      MODE_READ_SCREEN: begin
        if ((32'(in_item.read_row) < SCREEN_ROWS) &&
            (32'(in_item.read_column) < SCREEN_COLUMNS)) begin
          cls.op = OP_READ_SCREEN;
        end
      end
      MODE_READ_HISTORY: begin
        if (32'(in_item.read_column) < SCREEN_COLUMNS) begin
          cls.op = OP_READ_HISTORY;
        end
      end
      default: cls.op = OP_NOP;
    endcase
  end

  assign busy     = hold_off || (cmd_valid_r && q_full);
  assign accept   = start && !busy;
  assign push     = cmd_valid_r && !q_full;
  assign push_cmd = cmd_r;

  always_comb begin
    if (accept) begin
      cmd_valid_nxt = 1'b1;
    end else if (push) begin
      cmd_valid_nxt = 1'b0;
    end else begin
      cmd_valid_nxt = cmd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cls;
    end
  end

endmodule

// File: rtl/tcsu_back.sv
// ---------------------------------------------------------------------------
// tcsu_back
// Command sequencer: screen and history memories, cursor, scroll, reads.
// ---------------------------------------------------------------------------
`include "text_console_with_scrollback_unit_defines.svh"

module tcsu_back import tcsu_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS,
  parameter int HISTORY_DEPTH  = DEF_HISTORY_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] attr,
  input  logic       q_empty,
  input  tcsu_cmd_t  q_head,
  output logic       q_pop,
  output logic       clearing,
  output logic       out_strobe,
  output tcsu_out_t  out_item
);

  localparam int SCR_CELLS  = SCREEN_ROWS * SCREEN_COLUMNS;
  localparam int HIST_CELLS = HISTORY_DEPTH * SCREEN_COLUMNS;
  localparam int COL_W  = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W  = $clog2(SCREEN_ROWS);
  localparam int SA_W   = $clog2(SCR_CELLS);
  localparam int HL_W   = $clog2(HISTORY_DEPTH);
  localparam int HA_W   = $clog2(HIST_CELLS);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int LN_W   = (HL_W > ROW_W) ? HL_W : ROW_W;
  localparam int AD_W   = (HA_W > SA_W) ? HA_W : SA_W;
  localparam logic [COL_W:0] SC_END = (COL_W + 1)'(SCREEN_COLUMNS);
  localparam logic [15:0] RESET_BLANK = {RESET_ATTRIBUTE, CH_SPACE};

  tcsu_state_t state_r, state_nxt;

  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  phys_r, phys_nxt;
  logic [SA_W-1:0]   row_base_r, row_base_nxt;
  logic [ROW_W-1:0]  top_r, top_nxt;
  logic [SA_W-1:0]   top_base_r, top_base_nxt;
  logic [HL_W-1:0]   wline_r, wline_nxt;
  logic [HA_W-1:0]   hist_base_r, hist_base_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [TAB_W-1:0]  tab_left_r, tab_left_nxt;
  logic [COL_W:0]    sc_r, sc_nxt;
  logic [SA_W-1:0]   clr_r, clr_nxt;

  logic [7:0]        char_r, char_nxt;
  tcsu_cmd_t         req_r, req_nxt;
  logic [LN_W-1:0]   rd_line_r, rd_line_nxt;
  logic [AD_W-1:0]   rd_addr_r, rd_addr_nxt;
  logic [15:0]       cell_r, cell_nxt;
  logic              valid_r, valid_nxt;

  logic [15:0] scr_mem [SCR_CELLS];
  logic [15:0] hist_mem [HIST_CELLS];
  logic        scr_we, scr_re, hist_we, hist_re;
  logic [SA_W-1:0] scr_waddr, scr_raddr;
  logic [HA_W-1:0] hist_waddr;
  logic [15:0] scr_wdata, hist_wdata;
  logic [15:0] scr_rdata_r, hist_rdata_r;

  logic            col_last, row_last, age_ok;
  logic [ROW_W:0]  srow_sum;
  logic [HL_W:0]   hline_sum;
  logic [ROW_W:0]  cur_sum;
  logic [ROW_W-1:0] phys_chk;
  logic [SA_W-1:0] row_base_chk;

  assign col_last = (col_r == COL_W'(SCREEN_COLUMNS - 1));
  assign row_last = (row_r == ROW_W'(SCREEN_ROWS - 1));
  assign age_ok   = (32'(q_head.history_age) < 32'(fill_r));

  assign srow_sum  = (ROW_W + 1)'(top_r) + (ROW_W + 1)'(req_r.read_row);
  assign hline_sum = (HL_W + 1)'(wline_r) + (HL_W + 1)'(HISTORY_DEPTH - 1)
                   - (HL_W + 1)'(req_r.history_age);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == SA_W'(SCR_CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          case (q_head.op)
            OP_PLAIN, OP_TAB: state_nxt = ST_PUT;
            OP_NEWLINE:       state_nxt = row_last ? ST_SCROLL : ST_REPORT;
            OP_READ_SCREEN:   state_nxt = ST_RADDR;
            OP_READ_HISTORY:  state_nxt = age_ok ? ST_RADDR : ST_REPORT;
            default:          state_nxt = ST_REPORT;
          endcase
        end
      end
      ST_PUT: begin
        if (col_last && row_last) begin
          state_nxt = ST_SCROLL;
        end else if (tab_left_r == TAB_W'(1)) begin
          state_nxt = ST_REPORT;
        end
      end
      ST_SCROLL: begin
        if (sc_r == SC_END) begin
          state_nxt = (tab_left_r != '0) ? ST_PUT : ST_REPORT;
        end
      end
      ST_RADDR:  state_nxt = ST_RMUL;
      ST_RMUL:   state_nxt = ST_RMEM;
      ST_RMEM:   state_nxt = ST_RDATA;
      ST_RDATA:  state_nxt = ST_REPORT;
      ST_REPORT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // memory controls and result
  always_comb begin
    q_pop      = 1'b0;
    scr_we     = 1'b0;
    scr_waddr  = '0;
    scr_wdata  = '0;
    scr_re     = 1'b0;
    scr_raddr  = '0;
    hist_we    = 1'b0;
    hist_waddr = '0;
    hist_wdata = '0;
    hist_re    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        scr_we    = 1'b1;
        scr_waddr = clr_r;
        scr_wdata = RESET_BLANK;
      end
      ST_IDLE: begin
        q_pop = !q_empty;
        if (!q_empty && (q_head.op == OP_BACKSPACE) && (col_r != '0)) begin
          scr_we    = 1'b1;
          scr_waddr = row_base_r + SA_W'(col_r - 1'b1);
          scr_wdata = {attr, CH_SPACE};
        end
      end
      ST_PUT: begin
        scr_we    = 1'b1;
        scr_waddr = row_base_r + SA_W'(col_r);
        scr_wdata = {attr, char_r};
      end
      ST_SCROLL: begin
        // read cell k while cell k-1 goes to history and is blanked
        if (sc_r != SC_END) begin
          scr_re    = 1'b1;
          scr_raddr = top_base_r + SA_W'(sc_r);
        end
        if (sc_r != '0) begin
          scr_we     = 1'b1;
          scr_waddr  = top_base_r + SA_W'(sc_r - 1'b1);
          scr_wdata  = {attr, CH_SPACE};
          hist_we    = 1'b1;
          hist_waddr = hist_base_r + HA_W'(sc_r - 1'b1);
          hist_wdata = scr_rdata_r;
        end
      end
      ST_RMEM: begin
        scr_re    = (req_r.op == OP_READ_SCREEN);
        scr_raddr = SA_W'(rd_addr_r);
        hist_re   = (req_r.op == OP_READ_HISTORY);
      end
      default: begin
      end
    endcase
  end

  assign clearing   = (state_r == ST_CLEAR);
  assign out_strobe = (state_r == ST_REPORT);

  always_comb begin
    out_item.cursor_row    = 5'(row_r);
    out_item.cursor_column = 7'(col_r);
    out_item.cell_data     = cell_r;
    out_item.read_valid    = valid_r;
    out_item.history_lines = 13'(fill_r);
  end

  // datapath
  always_comb begin
    logic adv_line;
    adv_line      = 1'b0;
    row_nxt       = row_r;
    col_nxt       = col_r;
    phys_nxt      = phys_r;
    row_base_nxt  = row_base_r;
    top_nxt       = top_r;
    top_base_nxt  = top_base_r;
    wline_nxt     = wline_r;
    hist_base_nxt = hist_base_r;
    fill_nxt      = fill_r;
    tab_left_nxt  = tab_left_r;
    sc_nxt        = sc_r;
    clr_nxt       = clr_r;
    char_nxt      = char_r;
    req_nxt       = req_r;
    rd_line_nxt   = rd_line_r;
    rd_addr_nxt   = rd_addr_r;
    cell_nxt      = cell_r;
    valid_nxt     = valid_r;
    case (state_r)
      ST_CLEAR: clr_nxt = clr_r + 1'b1;
      ST_IDLE: begin
        if (!q_empty) begin
          req_nxt   = q_head;
          cell_nxt  = '0;
          valid_nxt = 1'b0;
          case (q_head.op)
            OP_PLAIN: begin
              char_nxt     = q_head.char_code;
              tab_left_nxt = TAB_W'(1);
            end
            OP_TAB: begin
              char_nxt     = CH_SPACE;
              tab_left_nxt = TAB_W'(TAB_STOP) - TAB_W'(col_r % COL_W'(TAB_STOP));
            end
            OP_NEWLINE: begin
              tab_left_nxt = '0;
              adv_line     = 1'b1;
            end
            OP_RETURN: col_nxt = '0;
            OP_BACKSPACE: begin
              if (col_r != '0) begin
                col_nxt = col_r - 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_PUT: begin
        tab_left_nxt = tab_left_r - 1'b1;
        if (col_last) begin
          adv_line = 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      ST_SCROLL: begin
        if (sc_r == SC_END) begin
          sc_nxt = '0;
          if (top_r == ROW_W'(SCREEN_ROWS - 1)) begin
            top_nxt      = '0;
            top_base_nxt = '0;
          end else begin
            top_nxt      = top_r + 1'b1;
            top_base_nxt = top_base_r + SA_W'(SCREEN_COLUMNS);
          end
          if (wline_r == HL_W'(HISTORY_DEPTH - 1)) begin
            wline_nxt     = '0;
            hist_base_nxt = '0;
          end else begin
            wline_nxt     = wline_r + 1'b1;
            hist_base_nxt = hist_base_r + HA_W'(SCREEN_COLUMNS);
          end
          if (fill_r != FILL_W'(HISTORY_DEPTH)) begin
            fill_nxt = fill_r + 1'b1;
          end
        end else begin
          sc_nxt = sc_r + 1'b1;
        end
      end
      ST_RADDR: begin
        if (req_r.op == OP_READ_HISTORY) begin
          rd_line_nxt = (hline_sum >= (HL_W + 1)'(HISTORY_DEPTH))
                      ? LN_W'(hline_sum - (HL_W + 1)'(HISTORY_DEPTH))
                      : LN_W'(hline_sum);
        end else begin
          rd_line_nxt = (srow_sum >= (ROW_W + 1)'(SCREEN_ROWS))
                      ? LN_W'(srow_sum - (ROW_W + 1)'(SCREEN_ROWS))
                      : LN_W'(srow_sum);
        end
      end
      ST_RMUL: begin
        rd_addr_nxt = AD_W'(AD_W'(rd_line_r) * AD_W'(SCREEN_COLUMNS)
                    + AD_W'(req_r.read_column));
      end
      ST_RDATA: begin
        cell_nxt  = (req_r.op == OP_READ_HISTORY) ? hist_rdata_r : scr_rdata_r;
        valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
    // cursor to column 0 of the next row; the physical row always advances
    if (adv_line) begin
      col_nxt = '0;
      if (!row_last) begin
        row_nxt = row_r + 1'b1;
      end
      if (phys_r == ROW_W'(SCREEN_ROWS - 1)) begin
        phys_nxt     = '0;
        row_base_nxt = '0;
      end else begin
        phys_nxt     = phys_r + 1'b1;
        row_base_nxt = row_base_r + SA_W'(SCREEN_COLUMNS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      row_r       <= '0;
      col_r       <= '0;
      phys_r      <= '0;
      row_base_r  <= '0;
      top_r       <= '0;
      top_base_r  <= '0;
      wline_r     <= '0;
      hist_base_r <= '0;
      fill_r      <= '0;
      tab_left_r  <= '0;
      sc_r        <= '0;
      clr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      phys_r      <= phys_nxt;
      row_base_r  <= row_base_nxt;
      top_r       <= top_nxt;
      top_base_r  <= top_base_nxt;
      wline_r     <= wline_nxt;
      hist_base_r <= hist_base_nxt;
      fill_r      <= fill_nxt;
      tab_left_r  <= tab_left_nxt;
      sc_r        <= sc_nxt;
      clr_r       <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r    <= char_nxt;
    req_r     <= req_nxt;
    rd_line_r <= rd_line_nxt;
    rd_addr_r <= rd_addr_nxt;
    cell_r    <= cell_nxt;
    valid_r   <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mem[scr_waddr] <= scr_wdata;
    end
    if (scr_re) begin
      scr_rdata_r <= scr_mem[scr_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (hist_re) begin
      hist_rdata_r <= hist_mem[HA_W'(rd_addr_r)];
    end
  end

  // cursor bookkeeping cross-checks
  assign cur_sum  = (ROW_W + 1)'(top_r) + (ROW_W + 1)'(row_r);
  assign phys_chk = (cur_sum >= (ROW_W + 1)'(SCREEN_ROWS))
                  ? ROW_W'(cur_sum - (ROW_W + 1)'(SCREEN_ROWS))
                  : ROW_W'(cur_sum);
  assign row_base_chk = SA_W'(SA_W'(phys_r) * SA_W'(SCREEN_COLUMNS));

  `TCSU_ASSERT_ALWAYS(a_fill_bound, fill_r <= FILL_W'(HISTORY_DEPTH), "history fill past depth")
  `TCSU_ASSERT_ALWAYS(a_cursor_bound, (32'(row_r) < SCREEN_ROWS) && (32'(col_r) < SCREEN_COLUMNS), "cursor off screen")
  `TCSU_ASSERT_IMPLY(a_phys_row, (state_r == ST_IDLE) || (state_r == ST_REPORT), phys_r == phys_chk, "cursor physical row out of step with top row")
  `TCSU_ASSERT_IMPLY(a_row_base, state_r == ST_IDLE, row_base_r == row_base_chk, "cursor row base out of step")
  `TCSU_ASSERT_NEXT(a_scroll_top, (state_r == ST_SCROLL) && (sc_r == SC_END), top_r != $past(top_r), "scroll did not advance top row")

endmodule
